// ===== src/mexp_pkg.sv =====
// Package with a shared type of the modular exponentiation block.
package mexp_pkg;

    // Commands from the sequencer to the modular multiplier.
    typedef struct packed {
        logic start;
        logic square;
    } mul_cmd_t;

endpackage

// ===== src/mexp_mulmod.sv =====
// Bit-serial modular multiplier (double-and-add) and serial base reducer.
module mexp_mulmod #(
    parameter int W = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mexp_pkg::mul_cmd_t  cmd,
    input  logic                reduce_start,
    input  logic [W-1:0]        a_in,
    input  logic [W-1:0]        b_in,
    input  logic [W-1:0]        m_in,
    output logic [W-1:0]        result,
    output logic                done
);
    import mexp_pkg::*;

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  acc_reg, acc_next;
    logic [W-1:0]  a_reg, a_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          red_reg, red_next;
    logic          done_reg, done_next;

    logic [W:0]    dbl;
    logic [W:0]    dbl_red;
    logic [W-1:0]  dacc;
    logic [W:0]    sum;
    logic [W-1:0]  step_acc;

    // Double the accumulator, or in reduce mode shift in the next bit of a.
    always_comb
    begin
        dbl      = {acc_reg, (red_reg ? a_reg[W-1] : 1'b0)};
        dbl_red  = (dbl >= {1'b0, m_in}) ? dbl - {1'b0, m_in} : dbl;
        dacc     = dbl_red[W-1:0];
        sum      = {1'b0, dacc} + {1'b0, b_in};
        if (!red_reg && a_reg[W-1])
        begin
            step_acc = (sum >= {1'b0, m_in}) ? W'(sum - {1'b0, m_in}) : sum[W-1:0];
        end
        else
        begin
            step_acc = dacc;
        end
    end

    always_comb
    begin
        acc_next  = acc_reg;
        a_next    = a_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        red_next  = red_reg;
        done_next = 1'b0;
        if (cmd.start || reduce_start)
        begin
            acc_next  = '0;
            a_next    = a_in;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
            red_next  = reduce_start;
        end
        else if (busy_reg)
        begin
            acc_next = step_acc;
            a_next   = {a_reg[W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            red_reg  <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            red_reg  <= red_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
    end

    assign result = acc_reg;
    assign done   = done_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("done while still busy");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg != '0))
        else $error("busy with zero count");
    a_done_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg) && ($past(cnt_reg) == CW'(1)))
        else $error("done not from last step");

endmodule

// ===== src/modular_exponentiation.sv =====
// Top level: right-to-left square-and-multiply sequencer around a serial multiplier.
//
//  channel | signals                                              | direction
//  in      | in_valid, in_stall, base/exponent/modulus_value      | request in
//  out     | out_valid, out_stall, power_result, zero_modulus_error | result out
//
// An item first runs the base reduction, then per exponent bit a square
// plus a multiply when the bit is set, all on the bit-serial multiplier.
// Moduli of zero and one skip the multiplier. Reset clears the sequencer.
// in_stall is high while an item is in work or its result waits; the result
// holds on the ports while out_stall is high.
module modular_exponentiation #(
    parameter int OPERAND_WIDTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] base_value,
    input  logic [63:0] exponent_value,
    input  logic [63:0] modulus_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] power_result,
    output logic        zero_modulus_error
);
    import mexp_pkg::*;

    localparam int W  = OPERAND_WIDTH;
    localparam int CW = $clog2(W + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_REDUCE = 3'd1;
    localparam logic [2:0] S_MUL    = 3'd2;
    localparam logic [2:0] S_SQR    = 3'd3;
    localparam logic [2:0] S_WAIT   = 3'd4;
    localparam logic [2:0] S_OUT    = 3'd5;

    logic [2:0]    state_reg, state_next;
    logic [W-1:0]  base_reg, base_next;
    logic [W-1:0]  exp_reg, exp_next;
    logic [W-1:0]  mod_reg, mod_next;
    logic [W-1:0]  acc_reg, acc_next;
    logic [CW-1:0] bit_reg, bit_next;
    logic          err_reg, err_next;
    logic          started_reg, started_next;

    mul_cmd_t      cmd;
    logic          reduce_start;
    logic [W-1:0]  mul_a, mul_b, mul_res;
    logic          mul_done;
    logic          accept;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);

    // The reducer shifts a through the multiplier with b unused.
    assign mul_a = (state_reg == S_REDUCE) ? base_reg :
                   (state_reg == S_MUL) ? acc_reg : base_reg;
    assign mul_b = base_reg;

    mexp_mulmod #(.W(W)) u_mul (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .reduce_start (reduce_start),
        .a_in         (mul_a),
        .b_in         (mul_b),
        .m_in         (mod_reg),
        .result       (mul_res),
        .done         (mul_done)
    );

    always_comb
    begin
        state_next   = state_reg;
        base_next    = base_reg;
        exp_next     = exp_reg;
        mod_next     = mod_reg;
        acc_next     = acc_reg;
        bit_next     = bit_reg;
        err_next     = err_reg;
        started_next = 1'b0;
        cmd.start    = 1'b0;
        cmd.square   = 1'b0;
        reduce_start = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    base_next = base_value[W-1:0];
                    exp_next  = exponent_value[W-1:0];
                    mod_next  = modulus_value[W-1:0];
                    acc_next  = W'(1);
                    bit_next  = CW'(W);
                    err_next  = (modulus_value[W-1:0] == '0);
                    if (modulus_value[W-1:0] <= W'(1))
                    begin
                        acc_next   = '0;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        started_next = 1'b1;
                        state_next   = S_REDUCE;
                    end
                end
            end
            S_REDUCE:
            begin
                reduce_start = started_reg;
                if (mul_done)
                begin
                    base_next    = mul_res;
                    started_next = 1'b1;
                    state_next   = exp_reg[0] ? S_MUL : S_SQR;
                end
            end
            S_MUL:
            begin
                cmd.start = started_reg;
                if (mul_done)
                begin
                    acc_next     = mul_res;
                    started_next = 1'b1;
                    state_next   = S_SQR;
                end
            end
            S_SQR:
            begin
                cmd.start  = started_reg;
                cmd.square = 1'b1;
                if (mul_done)
                begin
                    base_next = mul_res;
                    exp_next  = {1'b0, exp_reg[W-1:1]};
                    bit_next  = bit_reg - 1'b1;
                    if (bit_reg == CW'(1))
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        started_next = 1'b1;
                        state_next   = exp_reg[1] ? S_MUL : S_SQR;
                    end
                end
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            started_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            started_reg <= started_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
        exp_reg  <= exp_next;
        mod_reg  <= mod_next;
        acc_reg  <= acc_next;
        bit_reg  <= bit_next;
        err_reg  <= err_next;
    end

    assign out_valid          = (state_reg == S_OUT);
    assign power_result       = 64'(acc_reg);
    assign zero_modulus_error = err_reg;

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("ready while busy");
    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid && $stable(power_result))
        else $error("stalled result changed");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && zero_modulus_error) |-> (power_result == 64'd0))
        else $error("error with nonzero result");

endmodule
